// ----- rtl/lru_set_assoc_tag_directory_core_defines.svh -----
// ----------------------------------------------------------------------------
// lru set-associative tag directory: assertion macros
// concurrent assertion wrappers shared by the directory rtl
// ----------------------------------------------------------------------------
`ifndef LRU_SET_ASSOC_TAG_DIRECTORY_CORE_DEFINES_SVH
`define LRU_SET_ASSOC_TAG_DIRECTORY_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// clocked assertion, off while reset is high
`define LSAD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("lsad assertion failed");
// clocked assertion that also holds during reset
`define LSAD_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) (prop)) \
      else $error("lsad assertion failed");
`else
`define LSAD_ASSERT(lbl, clk, rst, prop)
`define LSAD_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ----- rtl/lsad_pkg.sv -----
// ----------------------------------------------------------------------------
// lsad_pkg
// shared types and constants of the lru set-associative tag directory
// ----------------------------------------------------------------------------
`default_nettype none

package lsad_pkg;

   localparam int ADDR_W     = 32;
   localparam int TAG_W      = 32;
   localparam int RSP_DATA_W = 40;

   // register index as decoded from paddr[2]
   localparam logic CSR_IDX_OFFSET = 1'b0;
   localparam logic CSR_IDX_SET    = 1'b1;

   localparam logic [3:0] OFFSET_BITS_RST = 4'd5;
   localparam logic [2:0] SET_BITS_RST    = 3'd6;

   typedef struct packed {
      logic [3:0] offset_bits;
      logic [2:0] set_bits;
   } cfg_type;

   typedef struct packed {
      logic             hit;
      logic             evicted;
      logic [TAG_W-1:0] evicted_tag;
   } result_type;

   function automatic int floor_log2(input int n);
      int r;
      r = 0;
      for (int i = 1; i < 31; i++) begin
         if ((n >> i) != 0) begin
            r = i;
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/lsad_csr.sv -----
// ----------------------------------------------------------------------------
// lsad_csr
// apb register file holding the line offset and set index widths
// ----------------------------------------------------------------------------
`default_nettype none

module lsad_csr (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            csr_psel,
   input  wire logic            csr_penable,
   input  wire logic            csr_pwrite,
   input  wire logic [2:0]      csr_paddr,
   input  wire logic [31:0]     csr_pwdata,
   output logic      [31:0]     csr_prdata,
   output logic                 csr_pready,
   output lsad_pkg::cfg_type    cfg
);
   import lsad_pkg::*;

   logic [3:0] offset_bits_ff, offset_bits_in;
   logic [2:0] set_bits_ff, set_bits_in;
   logic       wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      offset_bits_in = offset_bits_ff;
      set_bits_in    = set_bits_ff;
      if (wr_en) begin
         unique case (csr_paddr[2])
            CSR_IDX_OFFSET: offset_bits_in = csr_pwdata[3:0];
            CSR_IDX_SET:    set_bits_in    = csr_pwdata[2:0];
            default:        offset_bits_in = offset_bits_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_bits_ff <= OFFSET_BITS_RST;
         set_bits_ff    <= SET_BITS_RST;
      end else begin
         offset_bits_ff <= offset_bits_in;
         set_bits_ff    <= set_bits_in;
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         CSR_IDX_OFFSET: csr_prdata = {28'd0, offset_bits_ff};
         CSR_IDX_SET:    csr_prdata = {29'd0, set_bits_ff};
         default:        csr_prdata = 32'd0;
      endcase
   end

   assign cfg.offset_bits = offset_bits_ff;
   assign cfg.set_bits    = set_bits_ff;

endmodule

`default_nettype wire

// ----- rtl/lsad_store.sv -----
// ----------------------------------------------------------------------------
// lsad_store
// tag and replacement state memories, one set row per access, with a
// same-set bypass and a clearing pass of the state rows after reset
// ----------------------------------------------------------------------------
`default_nettype none

module lsad_store #(
   parameter int WAYS = 4,
   parameter int SETS = 64,
   parameter int IW   = 6,
   parameter int RW   = 2
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   output logic                              clr_busy,
   // read port, row lands in the registers below
   input  wire logic                         rd_en,
   input  wire logic [IW-1:0]                rd_set,
   output logic      [WAYS-1:0][31:0]        rd_tag,
   output logic      [WAYS-1:0]              rd_valid,
   output logic      [WAYS-1:0][RW-1:0]      rd_rank,
   // write port
   input  wire logic                         wr_en,
   input  wire logic                         wr_tag_en,
   input  wire logic [IW-1:0]                wr_set,
   input  wire logic [RW-1:0]                wr_way,
   input  wire logic [31:0]                  wr_tag,
   input  wire logic [WAYS-1:0]              wr_valid,
   input  wire logic [WAYS-1:0][RW-1:0]      wr_rank
);
   import lsad_pkg::*;

   localparam logic [IW-1:0] LAST_ROW = IW'(SETS - 1);

   logic [31:0]             tag_mem   [SETS][WAYS];
   logic [WAYS-1:0]         valid_mem [SETS];
   logic [WAYS-1:0][RW-1:0] rank_mem  [SETS];

   logic                    clr_busy_ff, clr_busy_in;
   logic [IW-1:0]           clr_idx_ff, clr_idx_in;
   logic [WAYS-1:0][31:0]   rd_tag_ff;
   logic [WAYS-1:0]         rd_valid_ff;
   logic [WAYS-1:0][RW-1:0] rd_rank_ff;
   logic                    same_row;

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_idx_in  = clr_idx_ff;
      if (clr_busy_ff) begin
         clr_idx_in = clr_idx_ff + IW'(1);
         if (clr_idx_ff == LAST_ROW) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_idx_ff  <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_idx_ff  <= clr_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         valid_mem[clr_idx_ff] <= '0;
         rank_mem[clr_idx_ff]  <= '0;
      end else if (wr_en) begin
         valid_mem[wr_set] <= wr_valid;
         rank_mem[wr_set]  <= wr_rank;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && wr_tag_en) begin
         tag_mem[wr_set][wr_way] <= wr_tag;
      end
   end

   // a row being written back in the same cycle is newer than the array
   assign same_row = wr_en && (wr_set == rd_set);

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_valid_ff <= same_row ? wr_valid : valid_mem[rd_set];
         rd_rank_ff  <= same_row ? wr_rank : rank_mem[rd_set];
         for (int w = 0; w < WAYS; w++) begin
            if (same_row && wr_tag_en && (wr_way == RW'(w))) begin
               rd_tag_ff[w] <= wr_tag;
            end else begin
               rd_tag_ff[w] <= tag_mem[rd_set][w];
            end
         end
      end
   end

   assign clr_busy = clr_busy_ff;
   assign rd_tag   = rd_tag_ff;
   assign rd_valid = rd_valid_ff;
   assign rd_rank  = rd_rank_ff;

endmodule

`default_nettype wire

// ----- rtl/lsad_lookup.sv -----
// ----------------------------------------------------------------------------
// lsad_lookup
// parallel tag compare over the ways of one set and lru rank update
// ----------------------------------------------------------------------------
`default_nettype none

module lsad_lookup #(
   parameter int WAYS = 4,
   parameter int RW   = 2
) (
   input  wire logic [31:0]                  lookup_tag,
   input  wire logic [WAYS-1:0][31:0]        tag_row,
   input  wire logic [WAYS-1:0]              valid_row,
   input  wire logic [WAYS-1:0][RW-1:0]      rank_row,
   output lsad_pkg::result_type              result,
   output logic                              tag_we,
   output logic      [RW-1:0]                way,
   output logic      [WAYS-1:0]              valid_new,
   output logic      [WAYS-1:0][RW-1:0]      rank_new
);
   import lsad_pkg::*;

   localparam logic [RW-1:0] RANK_MAX = RW'(WAYS - 1);

   logic            hit;
   logic            has_free;
   logic [RW-1:0]   hit_way;
   logic [RW-1:0]   free_way;
   logic [RW-1:0]   victim;
   logic [RW-1:0]   hit_rank;
   logic [WAYS-1:0] valid_eff;

   // lowest matching, lowest free, and the way holding the oldest rank
   always_comb begin
      hit      = 1'b0;
      hit_way  = '0;
      has_free = 1'b0;
      free_way = '0;
      victim   = '0;
      for (int i = WAYS - 1; i >= 0; i--) begin
         if (valid_row[i] && (tag_row[i] == lookup_tag)) begin
            hit     = 1'b1;
            hit_way = RW'(i);
         end
         if (!valid_row[i]) begin
            has_free = 1'b1;
            free_way = RW'(i);
         end
         if (rank_row[i] == RANK_MAX) begin
            victim = RW'(i);
         end
      end
   end

   assign hit_rank = rank_row[hit_way];

   always_comb begin
      valid_new          = valid_row;
      rank_new           = rank_row;
      valid_eff          = valid_row;
      result.hit         = hit;
      result.evicted     = 1'b0;
      result.evicted_tag = '0;
      tag_we             = !hit;
      way                = hit ? hit_way : (has_free ? free_way : victim);
      if (hit) begin
         for (int i = 0; i < WAYS; i++) begin
            if (valid_row[i] && (rank_row[i] < hit_rank)) begin
               rank_new[i] = rank_row[i] + RW'(1);
            end
         end
         rank_new[hit_way] = '0;
      end else begin
         if (!has_free) begin
            result.evicted     = 1'b1;
            result.evicted_tag = tag_row[victim];
            valid_eff[victim]  = 1'b0;
         end
         for (int i = 0; i < WAYS; i++) begin
            if (valid_eff[i] && (rank_row[i] < RANK_MAX)) begin
               rank_new[i] = rank_row[i] + RW'(1);
            end
         end
         valid_new      = valid_eff;
         valid_new[way] = 1'b1;
         rank_new[way]  = '0;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/lsad_out.sv -----
// ----------------------------------------------------------------------------
// lsad_out
// response register of the directory, packs hit, eviction flag and tag
// ----------------------------------------------------------------------------
`default_nettype none

module lsad_out (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               load,
   input  wire lsad_pkg::result_type               result,
   output logic                                    out_ready,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // [0] hit, [1] evicted, [33:2] evicted_tag, [39:34] zero
   output logic [lsad_pkg::RSP_DATA_W-1:0]         rsp_tdata
);
   import lsad_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff;

   assign out_ready = !valid_ff || rsp_tready;
   assign valid_in  = load || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {6'd0, data_ff.evicted_tag, data_ff.evicted, data_ff.hit};

endmodule

`default_nettype wire

// ----- rtl/lru_set_assoc_tag_directory_core.sv -----
// the request is registered in stage 1, its result then in the response register driving rsp_tvalid
// throughput: one request per cycle if rsp is not stalled, also back to back into the same set
// the set row is read at accept and written back when its result enters the response register
// reset: state rows are swept clear after reset, req_tready low meanwhile
// tag entries are not cleared; only valid ways are compared or reported
// ----------------------------------------------------------------------------
// lru_set_assoc_tag_directory_core
// set-associative tag directory with lru replacement and eviction report
// ----------------------------------------------------------------------------
`default_nettype none
`include "lru_set_assoc_tag_directory_core_defines.svh"

module lru_set_assoc_tag_directory_core #(
   parameter int WAYS = 4,
   parameter int SETS = 64
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // [31:0] address
   input  wire logic [lsad_pkg::ADDR_W-1:0]   req_tdata,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // [0] hit, [1] evicted, [33:2] evicted_tag, [39:34] zero
   output logic [lsad_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [2:0]                    csr_paddr,
   input  wire logic [31:0]                   csr_pwdata,
   output logic      [31:0]                   csr_prdata,
   output logic                               csr_pready
);
   import lsad_pkg::*;

   localparam int SET_LIM = floor_log2(SETS);
   localparam int IW      = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int RW      = (WAYS > 1) ? $clog2(WAYS) : 1;

   cfg_type                 cfg;
   logic                    clr_busy;
   logic                    accept;
   logic                    s1_adv;
   logic                    out_ready;

   logic [2:0]              sb_eff;
   logic [31:0]             set_mask;
   logic [31:0]             set_full;
   logic [IW-1:0]           req_set;
   logic [31:0]             req_tag;

   logic                    s1_valid_ff, s1_valid_in;
   logic [IW-1:0]           s1_set_ff;
   logic [31:0]             s1_tag_ff;

   logic [WAYS-1:0][31:0]   row_tag;
   logic [WAYS-1:0]         row_valid;
   logic [WAYS-1:0][RW-1:0] row_rank;
   result_type              result;
   logic                    tag_we;
   logic [RW-1:0]           upd_way;
   logic [WAYS-1:0]         valid_new;
   logic [WAYS-1:0][RW-1:0] rank_new;

   lsad_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // address split: set index above the line offset, tag above the set index
   assign sb_eff   = ({1'b0, cfg.set_bits} > 4'(SET_LIM)) ? 3'(SET_LIM) : cfg.set_bits;
   assign set_mask = (32'd1 << sb_eff) - 32'd1;
   assign set_full = (req_tdata >> cfg.offset_bits) & set_mask;
   assign req_set  = set_full[IW-1:0];
   assign req_tag  = req_tdata >> (5'(cfg.offset_bits) + 5'(sb_eff));

   assign s1_adv     = s1_valid_ff && out_ready;
   assign req_tready = !clr_busy && (!s1_valid_ff || s1_adv);
   assign accept     = req_tvalid && req_tready;
   assign s1_valid_in = accept || (s1_valid_ff && !s1_adv);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_set_ff <= req_set;
         s1_tag_ff <= req_tag;
      end
   end

   lsad_store #(
      .WAYS (WAYS),
      .SETS (SETS),
      .IW   (IW),
      .RW   (RW)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .clr_busy  (clr_busy),
      .rd_en     (accept),
      .rd_set    (req_set),
      .rd_tag    (row_tag),
      .rd_valid  (row_valid),
      .rd_rank   (row_rank),
      .wr_en     (s1_adv),
      .wr_tag_en (tag_we),
      .wr_set    (s1_set_ff),
      .wr_way    (upd_way),
      .wr_tag    (s1_tag_ff),
      .wr_valid  (valid_new),
      .wr_rank   (rank_new)
   );

   lsad_lookup #(
      .WAYS (WAYS),
      .RW   (RW)
   ) u_lookup (
      .lookup_tag (s1_tag_ff),
      .tag_row    (row_tag),
      .valid_row  (row_valid),
      .rank_row   (row_rank),
      .result     (result),
      .tag_we     (tag_we),
      .way        (upd_way),
      .valid_new  (valid_new),
      .rank_new   (rank_new)
   );

   lsad_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (s1_adv),
      .result     (result),
      .out_ready  (out_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   `LSAD_ASSERT_ALWAYS(a_no_req_while_clearing, clock, clr_busy |-> !req_tready)
   `LSAD_ASSERT(a_adv_gives_rsp, clock, reset, s1_adv |=> rsp_tvalid)
   `LSAD_ASSERT(a_stall_holds_stage, clock, reset,
      (s1_valid_ff && !out_ready) |=> (s1_valid_ff && $stable(s1_tag_ff)))
   `LSAD_ASSERT(a_tag_zero_unless_evicted, clock, reset,
      (s1_adv && !result.evicted) |=> (rsp_tdata[33:2] == 32'd0))

endmodule

`default_nettype wire
